/* src/assert_macros.svh */
// assertion macros used by the rtl top level
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// plain invariant, checked every cycle outside reset
`define ORB_ASSERT(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// same-cycle implication
`define ORB_ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

`endif

/* src/orb_pkg.sv */
// shared types and constants for the overwriting ring buffer
`timescale 1ns / 1ps

package orb_pkg;

    localparam int DEPTH     = 512;
    localparam int DATA_W    = 32;
    localparam int ADDR_W    = 9;
    localparam int CNT_W     = 10;
    localparam int OFF_W     = 9;
    localparam int IN_TDATA_W  = 48;
    localparam int OUT_TDATA_W = 48;
    localparam int OUT_TUSER_W = 3;

    localparam logic [CNT_W-1:0] CAP_RESET = CNT_W'(365);
    localparam logic [CNT_W-1:0] CAP_MAX   = CNT_W'(DEPTH);
    localparam logic [CNT_W-1:0] CAP_MIN   = CNT_W'(1);

    typedef enum logic [1:0] {
        MODE_ENQ  = 2'd0,
        MODE_DEQ  = 2'd1,
        MODE_PEEK = 2'd2,
        MODE_GET  = 2'd3
    } t_mode;

    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_EMPTY = 2'd1,
        ST_RANGE = 2'd2
    } t_status;

endpackage

/* src/overwriting_ring_buffer_top.sv */
// top level of the overwriting ring buffer
//
//  channel   dir  handshake               payload
//  s_axis    in   tvalid / tready         tuser: mode, tdata: entry_value, offset
//  m_axis    out  tvalid / tready         tuser: status, overwrote; tdata: read_value, count
//  cfg       in   i_cfg_we (no wait)      i_cfg_wdata: capacity
//
//  one request per cycle while m_axis takes results; a result passes through the read stage
//  (the ram read) and then the output register
//  pointers and fill update at the accept edge, so back-to-back requests need no forwarding
//  reset (i_rst_n low, synchronous) empties the buffer and sets capacity to 365
//  a stalled m_axis holds the result; the read stage keeps one more, then s_axis stalls
//  ram contents are not cleared; only the stored range is ever read
`timescale 1ns / 1ps
`include "assert_macros.svh"

module overwriting_ring_buffer_top (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    // request channel
    input  logic                               s_axis_tvalid,
    output logic                               s_axis_tready,
    input  logic [orb_pkg::IN_TDATA_W-1:0]     s_axis_tdata,   // [31:0] entry_value, [40:32] offset, zero pad
    input  logic [1:0]                         s_axis_tuser,   // [1:0] mode
    // result channel
    output logic                               m_axis_tvalid,
    input  logic                               m_axis_tready,
    output logic [orb_pkg::OUT_TDATA_W-1:0]    m_axis_tdata,   // [31:0] read_value, [41:32] count, zero pad
    output logic [orb_pkg::OUT_TUSER_W-1:0]    m_axis_tuser,   // [1:0] status, [2] overwrote
    // capacity register
    input  logic                               i_cfg_we,
    input  logic [orb_pkg::CNT_W-1:0]          i_cfg_wdata
);

    localparam int AW = orb_pkg::ADDR_W;
    localparam int CW = orb_pkg::CNT_W;
    localparam int DW = orb_pkg::DATA_W;

    // architectural state
    logic [CW-1:0] r_cap,  n_cap;
    logic [AW-1:0] r_head, n_head;
    logic [AW-1:0] r_tail, n_tail;
    logic [CW-1:0] r_fill, n_fill;

    // read stage (waiting on ram data)
    logic                r_p_valid;
    logic                r_p_rd,    n_p_rd;
    orb_pkg::t_status    r_p_status, n_p_status;
    logic                r_p_ovw,   n_p_ovw;
    logic [CW-1:0]       r_p_count;

    // output register
    logic                r_o_valid;
    logic [DW-1:0]       r_o_value;
    orb_pkg::t_status    r_o_status;
    logic                r_o_ovw;
    logic [CW-1:0]       r_o_count;

    // request fields
    orb_pkg::t_mode      w_mode;
    logic [DW-1:0]       w_word;
    logic [orb_pkg::OFF_W-1:0] w_off;

    logic                w_accept;
    logic                w_p_move;

    // pointer arithmetic
    logic [CW-1:0]       w_head_p1, w_tail_p1, w_pos_sum, w_pos_fix;
    logic [AW-1:0]       w_head_inc, w_tail_inc, w_pos;
    logic [CW-1:0]       w_cap_eff;

    // ram port
    logic                w_we, w_re;
    logic [AW-1:0]       w_waddr, w_raddr;
    logic [DW-1:0]       w_rdata;

    assign w_mode = orb_pkg::t_mode'(s_axis_tuser);
    assign w_word = s_axis_tdata[DW-1:0];
    assign w_off  = s_axis_tdata[DW+orb_pkg::OFF_W-1:DW];

    // handshakes: read stage drains into output register when it is free
    assign w_p_move      = r_p_valid && (!r_o_valid || m_axis_tready);
    assign s_axis_tready = !r_p_valid || w_p_move;
    assign w_accept      = s_axis_tvalid && s_axis_tready;

    // wrap increments
    assign w_head_p1  = {1'b0, r_head} + CW'(1);
    assign w_tail_p1  = {1'b0, r_tail} + CW'(1);
    assign w_head_inc = (w_head_p1 >= r_cap) ? '0 : w_head_p1[AW-1:0];
    assign w_tail_inc = (w_tail_p1 >= r_cap) ? '0 : w_tail_p1[AW-1:0];

    // get position: head + offset, one wrap at most since offset < fill <= cap
    assign w_pos_sum = {1'b0, r_head} + {1'b0, w_off};
    assign w_pos_fix = (w_pos_sum >= r_cap) ? (w_pos_sum - r_cap) : w_pos_sum;
    assign w_pos     = w_pos_fix[AW-1:0];

    // clamp written capacity to 1..depth
    always_comb begin
        if (i_cfg_wdata == '0) begin
            w_cap_eff = orb_pkg::CAP_MIN;
        end else if (i_cfg_wdata > orb_pkg::CAP_MAX) begin
            w_cap_eff = orb_pkg::CAP_MAX;
        end else begin
            w_cap_eff = i_cfg_wdata;
        end
    end

    // operation decode
    always_comb begin
        n_cap      = r_cap;
        n_head     = r_head;
        n_tail     = r_tail;
        n_fill     = r_fill;
        n_p_rd     = 1'b0;
        n_p_status = orb_pkg::ST_OK;
        n_p_ovw    = 1'b0;
        w_we       = 1'b0;
        w_re       = 1'b0;
        w_waddr    = r_tail;
        w_raddr    = r_head;

        if (i_cfg_we) begin
            // capacity write also empties the buffer
            n_cap  = w_cap_eff;
            n_head = '0;
            n_tail = '0;
            n_fill = '0;
        end else if (w_accept) begin
            case (w_mode)
                orb_pkg::MODE_ENQ: begin
                    w_we   = 1'b1;
                    n_tail = w_tail_inc;
                    if (r_fill < r_cap) begin
                        n_fill = r_fill + CW'(1);
                    end else begin
                        // full: drop the oldest
                        n_head  = w_head_inc;
                        n_p_ovw = 1'b1;
                    end
                end
                orb_pkg::MODE_DEQ, orb_pkg::MODE_PEEK: begin
                    if (r_fill == '0) begin
                        n_p_status = orb_pkg::ST_EMPTY;
                    end else begin
                        w_re   = 1'b1;
                        n_p_rd = 1'b1;
                        if (w_mode == orb_pkg::MODE_DEQ) begin
                            n_head = w_head_inc;
                            n_fill = r_fill - CW'(1);
                        end
                    end
                end
                orb_pkg::MODE_GET: begin
                    if ({1'b0, w_off} >= r_fill) begin
                        n_p_status = orb_pkg::ST_RANGE;
                    end else begin
                        w_re    = 1'b1;
                        n_p_rd  = 1'b1;
                        w_raddr = w_pos;
                    end
                end
                default: begin
                    n_p_status = orb_pkg::ST_OK;
                end
            endcase
        end
    end

    orb_ram #(
        .WIDTH (DW),
        .DEPTH (orb_pkg::DEPTH)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (w_waddr),
        .i_wdata (w_word),
        .i_re    (w_re),
        .i_raddr (w_raddr),
        .o_rdata (w_rdata)
    );

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cap     <= orb_pkg::CAP_RESET;
            r_head    <= '0;
            r_tail    <= '0;
            r_fill    <= '0;
            r_p_valid <= 1'b0;
            r_o_valid <= 1'b0;
        end else begin
            r_cap  <= n_cap;
            r_head <= n_head;
            r_tail <= n_tail;
            r_fill <= n_fill;
            if (w_accept) begin
                r_p_valid <= 1'b1;
            end else if (w_p_move) begin
                r_p_valid <= 1'b0;
            end
            if (w_p_move) begin
                r_o_valid <= 1'b1;
            end else if (m_axis_tready) begin
                r_o_valid <= 1'b0;
            end
        end
    end

    // payload registers; ram data holds while the read stage waits (no new read issued)
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_p_rd     <= n_p_rd;
            r_p_status <= n_p_status;
            r_p_ovw    <= n_p_ovw;
            r_p_count  <= n_fill;
        end
        if (w_p_move) begin
            r_o_value  <= r_p_rd ? w_rdata : '0;
            r_o_status <= r_p_status;
            r_o_ovw    <= r_p_ovw;
            r_o_count  <= r_p_count;
        end
    end

    assign m_axis_tvalid = r_o_valid;
    assign m_axis_tdata  = {{(orb_pkg::OUT_TDATA_W - DW - CW){1'b0}}, r_o_count, r_o_value};
    assign m_axis_tuser  = {r_o_ovw, r_o_status};

    // tail must sit fill entries past head, modulo capacity
    logic [CW:0] w_span, w_span_fix;
    assign w_span     = {2'b00, r_head} + {1'b0, r_fill};
    assign w_span_fix = (w_span >= {1'b0, r_cap}) ? (w_span - {1'b0, r_cap}) : w_span;

    `ORB_ASSERT(a_fill_le_cap, i_clk, i_rst_n, r_fill <= r_cap, "fill exceeds capacity")
    `ORB_ASSERT(a_ptr_in_cap, i_clk, i_rst_n,
        ({1'b0, r_head} < r_cap) && ({1'b0, r_tail} < r_cap), "pointer beyond capacity")
    `ORB_ASSERT(a_tail_track, i_clk, i_rst_n,
        w_span_fix[AW-1:0] == r_tail, "tail out of step with head and fill")
    `ORB_ASSERT_IMPL(a_ovw_full, i_clk, i_rst_n, r_o_valid && r_o_ovw,
        (r_o_count == r_cap) && (r_o_status == orb_pkg::ST_OK), "overwrite without full buffer")
    `ORB_ASSERT_IMPL(a_err_zero, i_clk, i_rst_n, r_o_valid && (r_o_status != orb_pkg::ST_OK),
        r_o_value == '0, "error result carries data")

endmodule

/* src/orb_ram.sv */
// generic single-port-write, single-port-read ram with registered read
`timescale 1ns / 1ps

module orb_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 512
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

/* bench/testbench.sv */
`timescale 1ns / 1ps
// self-checking bench for the overwriting ring buffer: directed table, then random requests

module testbench;
    import orb_pkg::*;

    // one expected result as it leaves the m_axis side
    typedef struct packed {
        logic [DATA_W-1:0] rd;
        t_status           st;
        logic              ovw;
        logic [CNT_W-1:0]  cnt;
    } t_response;

    // one row of the directed table: a capacity write or a request
    typedef struct packed {
        logic              cfg;
        logic [CNT_W-1:0]  cap;
        t_mode             mode;
        logic [DATA_W-1:0] value;
        logic [OFF_W-1:0]  off;
        logic              typed;     // expected result typed in below
        t_response         resp;
    } t_row;

    localparam int CYCLE_LIMIT  = 200000;
    localparam int PHASE_ITEMS  = 42;
    localparam int HOLD_CYCLES  = 60;
    localparam logic [CNT_W-1:0] CAP_OVER = CNT_W'(1023);   // above depth, clamps to it
    localparam logic [CNT_W-1:0] CAP_ZERO = CNT_W'(0);      // acts as one

    logic                   i_clk;
    logic                   i_rst_n        = 1'b0;
    logic                   s_axis_tvalid  = 1'b0;
    logic                   s_axis_tready;
    logic [IN_TDATA_W-1:0]  s_axis_tdata   = '0;
    logic [1:0]             s_axis_tuser   = MODE_ENQ;
    logic                   m_axis_tvalid;
    logic                   m_axis_tready  = 1'b0;
    logic [OUT_TDATA_W-1:0] m_axis_tdata;
    logic [OUT_TUSER_W-1:0] m_axis_tuser;
    logic                   i_cfg_we       = 1'b0;
    logic [CNT_W-1:0]       i_cfg_wdata    = '0;

    // shadow copy of the buffer state, advanced at every accepted request
    logic [DATA_W-1:0] ring_copy [DEPTH];
    logic [CNT_W-1:0]  cap_reg    = CAP_RESET;
    int                head_idx   = 0;
    int                tail_idx   = 0;
    int                fill_count = 0;

    t_response pending_responses [$];
    t_row      plan [$];

    int   requests_sent = 0;
    int   results_seen  = 0;
    int   error_count   = 0;
    int   cycle_count   = 0;
    logic rx_hold       = 1'b0;

    int phase_caps [9] = '{3, CAP_MIN, CAP_MAX, CAP_ZERO, 2, CAP_OVER, 7, 64, CAP_RESET};

    overwriting_ring_buffer_top u_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),    // [31:0] entry_value, [40:32] offset, zero pad
        .s_axis_tuser  (s_axis_tuser),    // [1:0] mode
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),    // [31:0] read_value, [41:32] count, zero pad
        .m_axis_tuser  (m_axis_tuser),    // [1:0] status, [2] overwrote
        .i_cfg_we      (i_cfg_we),
        .i_cfg_wdata   (i_cfg_wdata)
    );

    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    // idle mix: sender light / receiver heavy, then swapped, then no idling
    function automatic int sender_idle_pct();
        if (requests_sent < 140) return 10;
        if (requests_sent < 280) return 55;
        return 0;
    endfunction

    function automatic int receiver_idle_pct();
        if (requests_sent < 140) return 55;
        if (requests_sent < 280) return 10;
        return 0;
    endfunction

    // expected result of one request, updates the shadow state
    function automatic t_response buffer_response(t_mode m, logic [DATA_W-1:0] v,
                                                  logic [OFF_W-1:0] o);
        t_response r;
        int        lim;
        int        pos;
        r   = '0;
        lim = (cap_reg == 0) ? 1 : (cap_reg > DEPTH) ? DEPTH : int'(cap_reg);
        case (m)
            MODE_ENQ: begin
                ring_copy[tail_idx] = v;
                tail_idx = (tail_idx + 1 >= lim) ? 0 : tail_idx + 1;
                if (fill_count < lim) begin
                    fill_count++;
                end else begin
                    // full: oldest entry dropped, front moves on
                    head_idx = (head_idx + 1 >= lim) ? 0 : head_idx + 1;
                    r.ovw    = 1'b1;
                end
            end
            MODE_DEQ, MODE_PEEK: begin
                if (fill_count == 0) begin
                    r.st = ST_EMPTY;
                end else begin
                    r.rd = ring_copy[head_idx];
                    if (m == MODE_DEQ) begin
                        head_idx = (head_idx + 1 >= lim) ? 0 : head_idx + 1;
                        fill_count--;
                    end
                end
            end
            default: begin
                if (int'(o) >= fill_count) begin
                    r.st = ST_RANGE;
                end else begin
                    pos = head_idx + int'(o);
                    if (pos >= lim) pos -= lim;
                    r.rd = ring_copy[pos];
                end
            end
        endcase
        r.cnt = CNT_W'(fill_count);
        return r;
    endfunction

    function automatic t_response resp(logic [DATA_W-1:0] rd, t_status st, logic ovw,
                                       logic [CNT_W-1:0] cnt);
        t_response r;
        r.rd  = rd;
        r.st  = st;
        r.ovw = ovw;
        r.cnt = cnt;
        return r;
    endfunction

    // table rows: typed expectation, predictor-checked request, capacity write
    function automatic void add_checked(t_mode m, logic [DATA_W-1:0] v, logic [OFF_W-1:0] o,
                                        t_response want);
        plan.insert(plan.size(), t_row'{1'b0, '0, m, v, o, 1'b1, want});
    endfunction

    function automatic void add_predicted(t_mode m, logic [DATA_W-1:0] v,
                                          logic [OFF_W-1:0] o);
        plan.insert(plan.size(), t_row'{1'b0, '0, m, v, o, 1'b0, '0});
    endfunction

    function automatic void add_cap_write(logic [CNT_W-1:0] cap);
        plan.insert(plan.size(), t_row'{1'b1, cap, MODE_ENQ, '0, '0, 1'b0, '0});
    endfunction

    task automatic report_mismatch(input string what, input logic [DATA_W-1:0] got,
                                   input logic [DATA_W-1:0] want);
        $display("mismatch on %s in result %0d: got %h, expected %h",
                 what, results_seen, got, want);
        error_count++;
    endtask

    // offer one request, hold it until accepted, then record its expected result
    task automatic send_request(input t_mode m, input logic [DATA_W-1:0] v,
                                input logic [OFF_W-1:0] o, input logic typed,
                                input t_response typed_resp);
        t_response r;
        if ($urandom_range(0, 99) < sender_idle_pct()) begin
            s_axis_tvalid <= 1'b0;
            do @(posedge i_clk); while ($urandom_range(0, 99) < sender_idle_pct());
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= m;
        s_axis_tdata  <= {7'd0, o, v};
        do @(posedge i_clk); while (!s_axis_tready);
        r = buffer_response(m, v, o);
        pending_responses.insert(pending_responses.size(), typed ? typed_resp : r);
        requests_sent++;
    endtask

    // stop offering and wait until every result is back
    task automatic wait_drained();
        s_axis_tvalid <= 1'b0;
        while (pending_responses.size() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    // capacity write only with the block idle; it also empties the buffer
    task automatic write_capacity(input logic [CNT_W-1:0] cap);
        wait_drained();
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= cap;
        @(posedge i_clk);
        i_cfg_we    <= 1'b0;
        cap_reg    = cap;
        head_idx   = 0;
        tail_idx   = 0;
        fill_count = 0;
    endtask

    // random request; fill_bias leans toward enqueue to push the buffer into overwrite
    task automatic random_request(input bit fill_bias);
        int                pick;
        t_mode             m;
        logic [DATA_W-1:0] v;
        logic [OFF_W-1:0]  o;
        pick = $urandom_range(0, 99);
        if (fill_bias)
            m = (pick < 55) ? MODE_ENQ : (pick < 70) ? MODE_DEQ :
                (pick < 80) ? MODE_PEEK : MODE_GET;
        else
            m = (pick < 20) ? MODE_ENQ : (pick < 60) ? MODE_DEQ :
                (pick < 75) ? MODE_PEEK : MODE_GET;
        case ($urandom_range(0, 9))
            0:       v = '0;
            1:       v = '1;
            default: v = $urandom;
        endcase
        // offsets mostly within the stored range or at its edge
        if ($urandom_range(0, 9) < 7)
            o = OFF_W'($urandom_range(0, fill_count));
        else
            o = OFF_W'($urandom);
        send_request(m, v, o, 1'b0, '0);
    endtask

    // result side: check each accepted result, drive tready for the next cycle
    always @(posedge i_clk) begin : result_check
        t_response got;
        t_response want;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            got.rd  = m_axis_tdata[31:0];
            got.cnt = m_axis_tdata[41:32];
            got.st  = t_status'(m_axis_tuser[1:0]);
            got.ovw = m_axis_tuser[2];
            if (pending_responses.size() == 0) begin
                report_mismatch("result with no request outstanding", got.rd, '0);
            end else begin
                want = pending_responses.pop_front();
                if (got.rd !== want.rd)   report_mismatch("read_value", got.rd, want.rd);
                if (got.st !== want.st)
                    report_mismatch("status", DATA_W'(got.st), DATA_W'(want.st));
                if (got.ovw !== want.ovw)
                    report_mismatch("overwrote", DATA_W'(got.ovw), DATA_W'(want.ovw));
                if (got.cnt !== want.cnt)
                    report_mismatch("count", DATA_W'(got.cnt), DATA_W'(want.cnt));
            end
            results_seen++;
        end
        if (rx_hold) begin
            m_axis_tready <= 1'b0;
        end else begin
            m_axis_tready <= ($urandom_range(0, 99) >= receiver_idle_pct());
        end
    end

    // long receiver hold-offs so the block backs up and stalls s_axis
    initial begin : receiver_hold
        wait (results_seen >= 200);
        rx_hold <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge i_clk);
        rx_hold <= 1'b0;
        wait (results_seen >= 330);
        rx_hold <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge i_clk);
        rx_hold <= 1'b0;
    end

    // watchdog
    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("testbench failed");
            $finish;
        end
    end

    initial begin : stimulus
        int n;

        // empty buffer after reset, capacity 365
        add_checked(MODE_DEQ,  '0, '0,        resp('0, ST_EMPTY, 1'b0, 0));
        add_checked(MODE_PEEK, '0, '0,        resp('0, ST_EMPTY, 1'b0, 0));
        add_checked(MODE_GET,  '0, '0,        resp('0, ST_RANGE, 1'b0, 0));
        add_checked(MODE_GET,  '1, 9'd511,    resp('0, ST_RANGE, 1'b0, 0));
        // data extremes, in-range and out-of-range reads
        add_checked(MODE_ENQ,  '0, '1,        resp('0, ST_OK, 1'b0, 1));
        add_checked(MODE_ENQ,  '1, '0,        resp('0, ST_OK, 1'b0, 2));
        add_checked(MODE_PEEK, '0, '0,        resp('0, ST_OK, 1'b0, 2));
        add_checked(MODE_GET,  '0, 9'd1,      resp('1, ST_OK, 1'b0, 2));
        add_checked(MODE_GET,  '0, 9'd2,      resp('0, ST_RANGE, 1'b0, 2));
        add_checked(MODE_DEQ,  '0, '0,        resp('0, ST_OK, 1'b0, 1));
        add_checked(MODE_DEQ,  '0, '0,        resp('1, ST_OK, 1'b0, 0));
        add_checked(MODE_DEQ,  '0, '0,        resp('0, ST_EMPTY, 1'b0, 0));
        // capacity zero acts as one: every enqueue after the first overwrites
        add_cap_write(CAP_ZERO);
        add_checked(MODE_ENQ,  32'h1234_5678, '0, resp('0, ST_OK, 1'b0, 1));
        add_checked(MODE_ENQ,  32'h8765_4321, '0, resp('0, ST_OK, 1'b1, 1));
        add_checked(MODE_PEEK, '0, '0,            resp(32'h8765_4321, ST_OK, 1'b0, 1));
        add_checked(MODE_GET,  '0, 9'd1,          resp('0, ST_RANGE, 1'b0, 1));
        // capacity two: overwrite moves the front
        add_cap_write(2);
        add_checked(MODE_ENQ,  32'd1, '0,     resp('0, ST_OK, 1'b0, 1));
        add_checked(MODE_ENQ,  32'd2, '0,     resp('0, ST_OK, 1'b0, 2));
        add_checked(MODE_ENQ,  32'd3, '0,     resp('0, ST_OK, 1'b1, 2));
        add_checked(MODE_GET,  '0, 9'd1,      resp(32'd3, ST_OK, 1'b0, 2));
        add_checked(MODE_GET,  '0, 9'd0,      resp(32'd2, ST_OK, 1'b0, 2));
        add_checked(MODE_DEQ,  '0, '0,        resp(32'd2, ST_OK, 1'b0, 1));
        add_predicted(MODE_ENQ, 32'hDEAD_BEEF, '0);
        // capacity write empties the buffer; over-range value clamps to depth
        add_cap_write(CAP_OVER);
        add_checked(MODE_GET,  '0, '0,        resp('0, ST_RANGE, 1'b0, 0));
        add_predicted(MODE_ENQ, 32'hC0FF_EE00, '0);
        add_predicted(MODE_PEEK, '0, '0);

        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;

        foreach (plan[i]) begin
            if (plan[i].cfg)
                write_capacity(plan[i].cap);
            else
                send_request(plan[i].mode, plan[i].value, plan[i].off,
                             plan[i].typed, plan[i].resp);
        end

        // random phases, one per capacity setting
        foreach (phase_caps[p]) begin
            write_capacity(CNT_W'(phase_caps[p]));
            for (n = 0; n < PHASE_ITEMS; n++) begin
                // halfway through every third phase, a sender pause until everything is back
                if (n == PHASE_ITEMS / 2 && p % 3 == 0) wait_drained();
                random_request(n < (PHASE_ITEMS * 2) / 3);
            end
        end

        wait_drained();
        repeat (6) @(posedge i_clk);
        if (error_count == 0 && pending_responses.size() == 0)
            $display("testbench passed");
        else
            $display("testbench failed");
        $finish;
    end

endmodule
